@@ hdl/dad_pkg.sv @@
// Types, command codes and calendar helpers for the date adder.
// Used by dad_ctrl, dad_datapath and date_add_days; depends on nothing.
package dad_pkg;

  localparam logic [13:0] YEAR_MAX    = 14'd9999;
  localparam logic [3:0]  MONTH_DEC   = 4'd12;
  localparam logic [4:0]  DAY_DEC_END = 5'd31;
  localparam logic [13:0] YEAR_CYCLE  = 14'd400;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_INVALID  = 2'd1;
  localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

  typedef logic [2:0] dad_cmd_t;
  localparam dad_cmd_t CMD_NONE  = 3'd0;
  localparam dad_cmd_t CMD_LOAD  = 3'd1;
  localparam dad_cmd_t CMD_MOD   = 3'd2;
  localparam dad_cmd_t CMD_CHECK = 3'd3;
  localparam dad_cmd_t CMD_DOY   = 3'd4;
  localparam dad_cmd_t CMD_WALK  = 3'd5;

  typedef struct packed {
    logic [13:0] year_in;
    logic [3:0]  month_in;
    logic [4:0]  day_in;
    logic [13:0] days_to_add;
  } dad_in_t;

  typedef struct packed {
    logic [13:0] year_out;
    logic [3:0]  month_out;
    logic [4:0]  day_out;
    logic [1:0]  status;
  } dad_out_t;

  typedef struct packed {
    logic mod_done;
    logic date_bad;
    logic doy_done;
    logic walk_done;
    logic walk_ovf;
  } dad_stat_t;

  // Leap test on the year reduced modulo 400.
  function automatic logic is_leap(input logic [8:0] ymod);
    logic leap;
    leap = (ymod == 9'd0) ||
           ((ymod[1:0] == 2'd0) && (ymod != 9'd100) && (ymod != 9'd200) &&
            (ymod != 9'd300));
    return leap;
  endfunction

  // Length of a month; zero for a code that is not a month.
  function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                  len = 5'd30;
      4'd2:                                       len = leap ? 5'd29 : 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

endpackage

@@ hdl/dad_ctrl.sv @@
// Sequencing state machine for the date adder.
// Depends on dad_pkg; drives the datapath commands and the result strobe.
module dad_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  dad_pkg::dad_stat_t stat,
  output dad_pkg::dad_cmd_t cmd,
  output logic              busy,
  output logic              out_valid
);
  import dad_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MOD   = 3'd1;
  localparam logic [2:0] ST_CHECK = 3'd2;
  localparam logic [2:0] ST_DOY   = 3'd3;
  localparam logic [2:0] ST_WALK  = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic       valid_r, valid_nxt;

  always_comb begin
    state_nxt = state_r;
    valid_nxt = 1'b0;
    cmd       = CMD_NONE;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd       = CMD_LOAD;
          state_nxt = ST_MOD;
        end
      end
      ST_MOD: begin
        cmd = CMD_MOD;
        if (stat.mod_done) begin
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        cmd = CMD_CHECK;
        if (stat.date_bad) begin
          valid_nxt = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_DOY;
        end
      end
      ST_DOY: begin
        cmd = CMD_DOY;
        if (stat.doy_done) begin
          state_nxt = ST_WALK;
        end
      end
      ST_WALK: begin
        cmd = CMD_WALK;
        if (stat.walk_done || stat.walk_ovf) begin
          valid_nxt = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
    end
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = valid_r;

endmodule

@@ hdl/dad_datapath.sv @@
// Date registers, month walk arithmetic and result register of the date adder.
// Depends on dad_pkg; steered by dad_ctrl through command codes.
module dad_datapath #(
  parameter int ADD_DAYS_BITS = 14
) (
  input  logic               clk,
  input  dad_pkg::dad_cmd_t  cmd,
  input  dad_pkg::dad_in_t   in_data,
  output dad_pkg::dad_stat_t stat,
  output dad_pkg::dad_out_t  out_data
);
  import dad_pkg::*;

  localparam int ADD_W = (ADD_DAYS_BITS < 14) ? ADD_DAYS_BITS : 14;
  localparam int REM_W = ((ADD_W > 9) ? ADD_W : 9) + 1;

  logic [13:0]      year_r;
  logic [13:0]      ymod_r;
  logic [3:0]       month_r;
  logic [4:0]       day_r;
  logic [ADD_W-1:0] add_r;
  logic [REM_W-1:0] rem_r;
  logic [3:0]       m_r;
  dad_out_t         out_r;

  logic       leap;
  logic [4:0] start_len;
  logic [4:0] walk_len;
  logic       date_bad;
  logic       rem_over;
  logic       year_end;

  always_comb begin
    leap      = is_leap(ymod_r[8:0]);
    start_len = month_days(month_r, leap);
    walk_len  = month_days(m_r, leap);
    date_bad  = (year_r == 14'd0) || (year_r > YEAR_MAX) || (month_r == 4'd0) ||
                (month_r > MONTH_DEC) || (day_r == 5'd0) || (day_r > start_len);
    rem_over  = rem_r > REM_W'(walk_len);
    year_end  = rem_over && (m_r == MONTH_DEC);
  end

  assign stat.mod_done  = ymod_r < YEAR_CYCLE;
  assign stat.date_bad  = date_bad;
  assign stat.doy_done  = !(m_r < month_r);
  assign stat.walk_done = !rem_over;
  assign stat.walk_ovf  = year_end && (year_r == YEAR_MAX);

  always_ff @(posedge clk) begin
    case (cmd)
      CMD_LOAD: begin
        year_r  <= in_data.year_in;
        ymod_r  <= in_data.year_in;
        month_r <= in_data.month_in;
        day_r   <= in_data.day_in;
        add_r   <= in_data.days_to_add[ADD_W-1:0];
      end
      CMD_MOD: begin
        if (!stat.mod_done) begin
          ymod_r <= ymod_r - YEAR_CYCLE;
        end
      end
      CMD_CHECK: begin
        rem_r <= REM_W'(day_r);
        m_r   <= 4'd1;
        if (date_bad) begin
          out_r <= '{year_out: 14'd0, month_out: 4'd0, day_out: 5'd0,
                     status: STATUS_INVALID};
        end
      end
      CMD_DOY: begin
        if (m_r < month_r) begin
          rem_r <= rem_r + REM_W'(walk_len);
          m_r   <= m_r + 4'd1;
        end else begin
          rem_r <= rem_r + REM_W'(add_r);
          m_r   <= 4'd1;
        end
      end
      CMD_WALK: begin
        if (stat.walk_ovf) begin
          out_r <= '{year_out: YEAR_MAX, month_out: MONTH_DEC, day_out: DAY_DEC_END,
                     status: STATUS_OVERFLOW};
        end else if (rem_over) begin
          rem_r <= rem_r - REM_W'(walk_len);
          if (year_end) begin
            m_r    <= 4'd1;
            year_r <= year_r + 14'd1;
            ymod_r <= (ymod_r == YEAR_CYCLE - 14'd1) ? 14'd0 : ymod_r + 14'd1;
          end else begin
            m_r <= m_r + 4'd1;
          end
        end else begin
          out_r <= '{year_out: year_r, month_out: m_r, day_out: rem_r[4:0],
                     status: STATUS_OK};
        end
      end
      default: begin
      end
    endcase
  end

  assign out_data = out_r;

endmodule

@@ hdl/date_add_days.sv @@
// Gregorian date adder: start date plus a day count gives the later date.
// Steps: load, reduce the year modulo 400, check the date (an invalid date ends here),
// sum the day of year, add the count, then walk forward month by month until it fits.
// One word is worked on at a time; start is taken again once busy falls.
// The result strobe lasts one cycle and the receiver cannot stall it.
// Reset is synchronous and active low; it returns the controller to idle.
module date_add_days #(
  parameter int ADD_DAYS_BITS = 14
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  dad_pkg::dad_in_t  in_data,
  output logic              out_valid,
  output dad_pkg::dad_out_t out_data
);
  import dad_pkg::*;

  dad_cmd_t  cmd;
  dad_stat_t stat;

  dad_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  dad_datapath #(
    .ADD_DAYS_BITS (ADD_DAYS_BITS)
  ) u_datapath (
    .clk      (clk),
    .cmd      (cmd),
    .in_data  (in_data),
    .stat     (stat),
    .out_data (out_data)
  );

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("Accepted word did not raise busy.");

  a_valid_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(busy) && !$past(out_valid)))
    else $error("Result strobe without work in progress.");

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.status == STATUS_INVALID)) |->
      ((out_data.year_out == 14'd0) && (out_data.month_out == 4'd0) &&
       (out_data.day_out == 5'd0)))
    else $error("Invalid date result is not cleared.");

  a_overflow_sat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.status == STATUS_OVERFLOW)) |->
      ((out_data.year_out == YEAR_MAX) && (out_data.month_out == MONTH_DEC) &&
       (out_data.day_out == DAY_DEC_END)))
    else $error("Overflow result is not saturated.");

endmodule
